// ===== hw/rtl/lsc_pkg.sv =====
package lsc_pkg;

   typedef logic [2:0] class_type;
   typedef logic [2:0] lamps_type;

   localparam class_type CLS_OFF          = 3'd0;
   localparam class_type CLS_GREEN        = 3'd1;
   localparam class_type CLS_YELLOW       = 3'd2;
   localparam class_type CLS_RED          = 3'd3;
   localparam class_type CLS_FLASH_YELLOW = 3'd4;
   localparam class_type CLS_FLASH_RED    = 3'd5;
   localparam class_type CLS_UNKNOWN      = 3'd6;

   // lamp vector is {red, yellow, green}
   localparam lamps_type LAMPS_NONE   = 3'b000;
   localparam lamps_type LAMPS_GREEN  = 3'b001;
   localparam lamps_type LAMPS_YELLOW = 3'b010;
   localparam lamps_type LAMPS_RED    = 3'b100;

   localparam int          TIME_BITS_DEFAULT = 32;
   localparam logic [31:0] TIMEOUT_RESET     = 32'd5000;

endpackage

// ===== hw/rtl/lsc_core.sv =====
module lsc_core
   import lsc_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  lamps_type            lamps,
   input  logic [TIME_BITS-1:0] now_t,
   input  logic [31:0]          timeout,
   output class_type            class_next
);

   localparam int CMP_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

   class_type            class_ff, class_in;
   logic [TIME_BITS-1:0] red_seen_ff, red_seen_in;
   logic [TIME_BITS-1:0] yellow_seen_ff, yellow_seen_in;
   logic [TIME_BITS-1:0] green_seen_ff, green_seen_in;

   logic [TIME_BITS-1:0] red_elapsed;
   logic [TIME_BITS-1:0] yellow_elapsed;
   logic                 red_timed_out;
   logic                 yellow_timed_out;
   logic                 red_newest;
   logic                 yellow_newest;

   assign red_elapsed      = now_t - red_seen_ff;
   assign yellow_elapsed   = now_t - yellow_seen_ff;
   assign red_timed_out    = CMP_BITS'(red_elapsed) > CMP_BITS'(timeout);
   assign yellow_timed_out = CMP_BITS'(yellow_elapsed) > CMP_BITS'(timeout);
   assign red_newest       = (red_seen_ff > yellow_seen_ff) && (red_seen_ff > green_seen_ff);
   assign yellow_newest    = (yellow_seen_ff > red_seen_ff) && (yellow_seen_ff > green_seen_ff);

   always_comb begin
      class_in       = class_ff;
      red_seen_in    = red_seen_ff;
      yellow_seen_in = yellow_seen_ff;
      green_seen_in  = green_seen_ff;
      case (lamps)
         LAMPS_NONE: begin
            if (class_ff == CLS_FLASH_RED) begin
               if (red_timed_out) begin
                  class_in = CLS_OFF;
               end
            end else if (class_ff == CLS_FLASH_YELLOW) begin
               if (yellow_timed_out) begin
                  class_in = CLS_OFF;
               end
            end else begin
               class_in = CLS_OFF;
            end
         end
         LAMPS_GREEN: begin
            class_in      = CLS_GREEN;
            green_seen_in = now_t;
         end
         LAMPS_YELLOW: begin
            if ((class_ff inside {CLS_OFF, CLS_FLASH_YELLOW}) && yellow_newest) begin
               class_in = CLS_FLASH_YELLOW;
            end else begin
               class_in = CLS_YELLOW;
            end
            yellow_seen_in = now_t;
         end
         LAMPS_RED: begin
            if ((class_ff inside {CLS_OFF, CLS_FLASH_RED}) && red_newest) begin
               class_in = CLS_FLASH_RED;
            end else begin
               class_in = CLS_RED;
            end
            red_seen_in = now_t;
         end
         default: begin
            class_in = CLS_UNKNOWN;
         end
      endcase
   end

   assign class_next = class_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         class_ff       <= CLS_OFF;
         red_seen_ff    <= '0;
         yellow_seen_ff <= '0;
         green_seen_ff  <= '0;
      end else if (step) begin
         class_ff       <= class_in;
         red_seen_ff    <= red_seen_in;
         yellow_seen_ff <= yellow_seen_in;
         green_seen_ff  <= green_seen_in;
      end
   end

endmodule

// ===== hw/rtl/lamp_state_classifier_top.sv =====
// Lamp state classifier: takes one sample (three lamp bits and a millisecond
// timestamp) per transfer and returns one light state per sample, in order.
// A new sample can be taken every cycle unless a waiting result blocks the input
// register; a result is offered from the result register, which the input register
// feeds through the classifier logic, and the input keeps flowing while a result
// waits as long as the input register is free.
// The off timeout register resets to 5000 ms and should be written only while
// no sample is in flight.
module lamp_state_classifier_top
   import lsc_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_red_lit,
   input  logic        req_yellow_lit,
   input  logic        req_green_lit,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_light_state,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic                 s1_valid_ff, s1_valid_in;
   lamps_type            s1_lamps_ff;
   logic [TIME_BITS-1:0] s1_now_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   class_type            rsp_light_state_ff;
   logic [31:0]          timeout_ff;

   logic      req_xfer;
   logic      step;
   class_type class_next;

   assign step         = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || step;
   assign req_xfer     = req_valid && req_ready;
   assign s1_valid_in  = req_xfer || (s1_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_lamps_ff <= {req_red_lit, req_yellow_lit, req_green_lit};
         s1_now_ff   <= TIME_BITS'(req_now_ms);
      end
      if (step) begin
         rsp_light_state_ff <= class_next;
      end
   end

   lsc_core #(
      .TIME_BITS(TIME_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .lamps      (s1_lamps_ff),
      .now_t      (s1_now_ff),
      .timeout    (timeout_ff),
      .class_next (class_next)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_light_state = rsp_light_state_ff;

   a_two_lamps_unknown: assert property (@(posedge clock) disable iff (reset)
      step && ($countones(s1_lamps_ff) > 1) |=> rsp_light_state_ff == CLS_UNKNOWN)
      else $error("two or more lamps not reported unknown");

   a_green_steady: assert property (@(posedge clock) disable iff (reset)
      step && (s1_lamps_ff == LAMPS_GREEN) |=> rsp_light_state_ff == CLS_GREEN)
      else $error("lone green not reported green");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled with room in the pipeline");

   a_state_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_light_state_ff != 3'd7)
      else $error("light state out of range");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import lsc_pkg::*;

   localparam int ITEMS_PER_PHASE = 220;
   localparam int PHASE_COUNT     = 8;
   localparam int HOLDOFF_CYCLES  = 300;
   localparam int TAIL_CYCLES     = 8;
   localparam int CYCLE_LIMIT     = 500000;

   typedef struct {
      lamps_type   lamps;
      logic [31:0] now_ms;
      bit          typed;
      class_type   light_state;
   } sample_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_red_lit = 1'b0;
   logic        req_yellow_lit = 1'b0;
   logic        req_green_lit = 1'b0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_light_state;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   // predictor state
   class_type   lamp_class = CLS_OFF;
   logic [31:0] red_seen_ms = '0;
   logic [31:0] yellow_seen_ms = '0;
   logic [31:0] green_seen_ms = '0;
   logic [31:0] timeout_ms = TIMEOUT_RESET;

   class_type   light_state_q[$];
   class_type   expected_state;

   int          sender_idle_pct = 0;
   int          rsp_stall_pct = 0;
   bit          holdoff_req = 1'b0;
   bit          holdoff_ack = 1'b0;
   int          holdoff_left = 0;
   int          cycle_count = 0;
   int          failures = 0;
   int          samples_sent = 0;
   int          results_checked = 0;
   int          flash_yellow_hits = 0;
   int          flash_red_hits = 0;
   int          timeout_writes = 0;
   logic [31:0] sim_ms = '0;

   sample_row_type directed_rows [25] = '{
      '{LAMPS_NONE,                            32'd0,          1'b1, CLS_OFF},
      '{LAMPS_YELLOW,                          32'd100,        1'b1, CLS_YELLOW},
      '{LAMPS_NONE,                            32'd200,        1'b1, CLS_OFF},
      '{LAMPS_YELLOW,                          32'd1000,       1'b0, CLS_OFF},
      '{LAMPS_NONE,                            32'd6000,       1'b0, CLS_OFF},
      '{LAMPS_NONE,                            32'd6001,       1'b0, CLS_OFF},
      '{LAMPS_RED,                             32'd7000,       1'b0, CLS_OFF},
      '{LAMPS_NONE,                            32'd7001,       1'b1, CLS_OFF},
      '{LAMPS_RED,                             32'd8000,       1'b0, CLS_OFF},
      '{LAMPS_RED,                             32'd9000,       1'b0, CLS_OFF},
      '{LAMPS_YELLOW,                          32'd9500,       1'b0, CLS_OFF},
      '{LAMPS_RED,                             32'd10000,      1'b0, CLS_OFF},
      '{LAMPS_GREEN,                           32'hFFFF_FFFF,  1'b1, CLS_GREEN},
      '{LAMPS_NONE,                            32'd0,          1'b1, CLS_OFF},
      '{LAMPS_RED,                             32'd11000,      1'b0, CLS_OFF},
      '{LAMPS_RED | LAMPS_YELLOW | LAMPS_GREEN, 32'd0,         1'b1, CLS_UNKNOWN},
      '{LAMPS_RED | LAMPS_YELLOW,              32'hFFFF_FFFF,  1'b1, CLS_UNKNOWN},
      '{LAMPS_RED | LAMPS_GREEN,               32'h5555_5555,  1'b1, CLS_UNKNOWN},
      '{LAMPS_YELLOW | LAMPS_GREEN,            32'hAAAA_AAAA,  1'b1, CLS_UNKNOWN},
      '{LAMPS_NONE,                            32'd3,          1'b1, CLS_OFF},
      '{LAMPS_GREEN,                           32'd0,          1'b1, CLS_GREEN},
      '{LAMPS_NONE,                            32'd5,          1'b1, CLS_OFF},
      '{LAMPS_YELLOW,                          32'd11000,      1'b0, CLS_OFF},
      '{LAMPS_NONE,                            32'd11001,      1'b1, CLS_OFF},
      '{LAMPS_YELLOW,                          32'd12000,      1'b0, CLS_OFF}
   };

   lamp_state_classifier_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red_lit     (req_red_lit),
      .req_yellow_lit  (req_yellow_lit),
      .req_green_lit   (req_green_lit),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_light_state (rsp_light_state),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (holdoff_req != holdoff_ack) begin
         holdoff_ack  <= holdoff_req;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (light_state_q.size() == 0) begin
            $error("light_state: no transfer expected, got %0d", rsp_light_state);
            failures++;
         end else begin
            expected_state = light_state_q.pop_front();
            results_checked++;
            if (rsp_light_state !== expected_state) begin
               $error("light_state: expected %0d, got %0d", expected_state, rsp_light_state);
               failures++;
            end
            if (expected_state == CLS_FLASH_YELLOW) flash_yellow_hits++;
            if (expected_state == CLS_FLASH_RED) flash_red_hits++;
         end
      end
   end

   function automatic class_type classify_sample(input lamps_type lamps,
                                                 input logic [31:0] now_ms);
      logic [31:0] elapsed;
      case (lamps)
         LAMPS_NONE: begin
            if (lamp_class == CLS_FLASH_RED) begin
               elapsed = now_ms - red_seen_ms;
               if (elapsed > timeout_ms) lamp_class = CLS_OFF;
            end else if (lamp_class == CLS_FLASH_YELLOW) begin
               elapsed = now_ms - yellow_seen_ms;
               if (elapsed > timeout_ms) lamp_class = CLS_OFF;
            end else begin
               lamp_class = CLS_OFF;
            end
         end
         LAMPS_GREEN: begin
            green_seen_ms = now_ms;
            lamp_class    = CLS_GREEN;
         end
         LAMPS_YELLOW: begin
            if ((lamp_class == CLS_OFF || lamp_class == CLS_FLASH_YELLOW) &&
                yellow_seen_ms > red_seen_ms && yellow_seen_ms > green_seen_ms)
               lamp_class = CLS_FLASH_YELLOW;
            else
               lamp_class = CLS_YELLOW;
            yellow_seen_ms = now_ms;
         end
         LAMPS_RED: begin
            if ((lamp_class == CLS_OFF || lamp_class == CLS_FLASH_RED) &&
                red_seen_ms > yellow_seen_ms && red_seen_ms > green_seen_ms)
               lamp_class = CLS_FLASH_RED;
            else
               lamp_class = CLS_RED;
            red_seen_ms = now_ms;
         end
         default: lamp_class = CLS_UNKNOWN;
      endcase
      return lamp_class;
   endfunction

   // one sample transfer; a typed expectation overrides the predictor's
   task automatic send_sample(input lamps_type lamps, input logic [31:0] now_ms,
                              input bit typed, input class_type typed_state);
      class_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_red_lit    <= lamps[2];
      req_yellow_lit <= lamps[1];
      req_green_lit  <= lamps[0];
      req_now_ms     <= now_ms;
      do @(posedge clock); while (!req_ready);
      predicted = classify_sample(lamps, now_ms);
      light_state_q.push_back(typed ? typed_state : predicted);
      samples_sent++;
   endtask

   task automatic send_random(input lamps_type lamps, input logic [31:0] now_ms);
      send_sample(lamps, now_ms, 1'b0, CLS_OFF);
   endtask

   task automatic write_timeout(input logic [31:0] value);
      while (light_state_q.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      timeout_ms  = value;
      timeout_writes++;
   endtask

   function automatic logic [31:0] next_ms();
      case ($urandom_range(6))
         0:       sim_ms = sim_ms;
         1, 2:    sim_ms = sim_ms + 32'($urandom_range(1, 64));
         3, 4:    sim_ms = sim_ms + timeout_ms + 32'($urandom_range(0, 2)) - 32'd1;
         5:       sim_ms = sim_ms + 32'($urandom_range(1, 6000));
         default: sim_ms = sim_ms + $urandom();
      endcase
      return sim_ms;
   endfunction

   task automatic run_random(input int count);
      int        stop_at;
      int        reps;
      int        gaps;
      lamps_type colour;
      stop_at = samples_sent + count;
      while (samples_sent < stop_at) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
               // flashing run: one colour, dark gaps between blinks
               colour = $urandom_range(1) ? LAMPS_RED : LAMPS_YELLOW;
               reps   = $urandom_range(2, 6);
               for (int i = 0; i < reps; i++) begin
                  send_random(colour, next_ms());
                  gaps = $urandom_range(0, 3);
                  for (int j = 0; j < gaps; j++) send_random(LAMPS_NONE, next_ms());
               end
            end
            5, 6: begin
               send_random(LAMPS_GREEN, next_ms());
               send_random(LAMPS_YELLOW, next_ms());
               if ($urandom_range(1)) send_random(LAMPS_NONE, next_ms());
               send_random(LAMPS_RED, next_ms());
            end
            7: begin
               reps = $urandom_range(1, 4);
               for (int i = 0; i < reps; i++)
                  send_random(lamps_type'($urandom_range(7)), $urandom());
            end
            8: sim_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 200));
            default: begin
               send_random(lamps_type'($urandom_range(3, 7)) | LAMPS_YELLOW, next_ms());
               send_random(LAMPS_NONE, next_ms());
            end
         endcase
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      logic [31:0] phase_timeouts [PHASE_COUNT];
      phase_timeouts = '{32'd0, 32'hFFFF_FFFF, 32'd20, TIMEOUT_RESET, 32'd1,
                         32'hFFFF_FFFE, 32'd100, 32'($urandom_range(2, 3000))};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_sample(directed_rows[i].lamps, directed_rows[i].now_ms,
                     directed_rows[i].typed, directed_rows[i].light_state);
      req_valid <= 1'b0;
      sim_ms = 32'd20000;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_timeout(phase_timeouts[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin sender_idle_pct = 86; rsp_stall_pct <= 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct <= 86; end
            default: begin sender_idle_pct = 23; rsp_stall_pct <= 23; end
         endcase
         // long receiver hold-off while samples keep coming
         if (p % 4 == 0) holdoff_req <= ~holdoff_req;
         run_random(ITEMS_PER_PHASE);
      end

      while (light_state_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);

      $display("ran %0d samples with %0d checked results over %0d timeout settings",
               samples_sent, results_checked, timeout_writes);
      $display("flashing yellow results: %0d, flashing red results: %0d",
               flash_yellow_hits, flash_red_hits);
      if (failures == 0 && light_state_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/lsc_pkg.sv
hw/rtl/lsc_core.sv
hw/rtl/lamp_state_classifier_top.sv
tb/tb.sv
